// ===== hw/rtl/dcc_pkg.sv =====
// package for the dcc loco table speed packet generator
// holds field widths, request kinds, priorities and the 28-step encoder
`timescale 1ns / 1ps
package dcc_pkg;
   localparam int TableEntriesDefault  = 16;
   localparam int RefreshPhasesDefault = 11;
   localparam int AddrW = 14;
   localparam int EntryW = 1 + AddrW + 1 + 8 + 1;

   typedef enum logic [2:0] {
      KIND_ENSURE   = 3'd0,
      KIND_FORGET   = 3'd1,
      KIND_THROTTLE = 3'd2,
      KIND_ESTOP    = 3'd3,
      KIND_BCAST    = 3'd4,
      KIND_REFRESH  = 3'd5
   } kind_type;

   localparam logic [1:0] PRIO_EMERG = 2'd0;
   localparam logic [1:0] PRIO_HIGH  = 2'd1;
   localparam logic [1:0] PRIO_LOW   = 2'd2;

   localparam logic CSR_SHORT_LIMIT = 1'b0;
   localparam logic CSR_NEW_MODE    = 1'b1;

   typedef struct packed {
      logic             active;
      logic [AddrW-1:0] addr;
      logic             lng;
      logic [7:0]       step;
      logic             mode;
   } entry_type;

   // step index 2..127 to 28-step code, divide by 46 as multiply by 1425 >> 16
   function automatic logic [7:0] code_28(input logic [7:0] step);
      logic [6:0]  spd;
      logic [10:0] num;
      logic [20:0] prod;
      logic [4:0]  s28;
      logic [4:0]  code;
      logic [7:0]  res;
      spd = step[6:0];
      num = 11'(spd) * 11'd10 + 11'd36;
      prod = 21'(num) * 21'd1425;
      s28 = prod[20:16];
      if (spd <= 7'd1) code = 5'(spd);
      else begin
         code = 5'((6'(s28) + 6'd3) >> 1);
         if (!s28[0]) code = code | 5'h10;
      end
      res = 8'h40 | 8'(code);
      if (step[7]) res = res | 8'h20;
      return res;
   endfunction
endpackage

// ===== hw/rtl/dcc_if.sv =====
// valid/ready channel interfaces for request and response
// no dependencies
`timescale 1ns / 1ps
interface dcc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [13:0] loco_address;
   logic        want_long;
   logic [6:0]  speed_value;
   logic        forward_dir;
   modport source (output valid, kind, loco_address, want_long, speed_value,
                   forward_dir, input ready);
   modport sink (input valid, kind, loco_address, want_long, speed_value,
                 forward_dir, output ready);
endinterface

interface dcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  packet_byte;
   logic        end_of_packet;
   logic [1:0]  priority_res;
   logic [1:0]  repeat_count;
   logic [13:0] target_address;
   logic        last;
   modport source (output valid, packet_byte, end_of_packet, priority_res,
                   repeat_count, target_address, last, input ready);
   modport sink (input valid, packet_byte, end_of_packet, priority_res,
                 repeat_count, target_address, last, output ready);
endinterface

// ===== hw/rtl/dcc_ram.sv =====
// generic single-port-write ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
module dcc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/dcc_loco_table_speed_packet_gen_unit.sv =====
// DCC loco table and speed packet generator top level
// depends on dcc_pkg, dcc_if, dcc_ram
//
// Usage: requests arrive on req (valid/ready) and carry a kind, an address,
// the long-form wish, a speed step and a direction. Response items leave on
// rsp, one per DCC packet byte (checksum excluded), with end_of_packet on the
// final byte of each packet and last on the final byte caused by a request.
// The csr port writes the short address limit (index 0) and the speed mode of
// new entries (index 1); the index is a single bit.
// The loco table sits in one ram with a registered read. Each table request
// (ensure, forget, throttle, estop) walks every table entry, reading then
// checking each one, then decides and writes the entry back, except for an
// estop, a forget that misses, or a full table. A refresh tick in the
// speed phase first walks the table to find the last active entry, then
// walks it again up to that entry, sending up to four bytes for each active
// entry. After reset a clearing pass writes every entry inactive, during
// which no request is accepted. When the receiver stalls, the byte in the
// output register holds and the block waits.
`timescale 1ns / 1ps
module dcc_loco_table_speed_packet_gen_unit #(
   parameter int TABLE_ENTRIES  = dcc_pkg::TableEntriesDefault,
   parameter int REFRESH_PHASES = dcc_pkg::RefreshPhasesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data,
   dcc_req_if.sink    req,
   dcc_rsp_if.source  rsp
);
   import dcc_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int RamD = (TABLE_ENTRIES > 1) ? TABLE_ENTRIES : 2;
   localparam int PhW  = (REFRESH_PHASES > 1) ? $clog2(REFRESH_PHASES) : 1;
   localparam logic [IdxW:0] LastIdx = (IdxW+1)'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SREAD, ST_SCHECK, ST_DECIDE, ST_WRITE,
      ST_EMIT, ST_RREAD, ST_RCHECK, ST_REMIT, ST_DONE
   } state_type;

   state_type        state_ff;
   logic [IdxW:0]    idx_ff;
   logic [7:0]       limit_ff;
   logic             newmode_ff;
   logic [PhW-1:0]   phase_ff;
   logic [2:0]       kind_ff;
   logic [AddrW-1:0] addr_ff;
   logic             wlong_ff;
   logic [7:0]       step_ff;
   logic             found_ff, free_ff;
   logic [IdxW-1:0]  hit_ff, free_idx_ff;
   entry_type        hit_e_ff;
   logic             any_ff;
   logic [IdxW-1:0]  lastact_ff;
   // packet being sent
   logic [7:0]       pb_ff [4];
   logic [2:0]       plen_ff, pos_ff;
   logic [1:0]       pprio_ff, prep_ff;
   logic [AddrW-1:0] paddr_ff;
   logic             more_ff;
   logic             ov_ff;
   logic [7:0]       ob_ff;
   logic             oeop_ff, olast_ff;
   logic [1:0]       oprio_ff, orep_ff;
   logic [AddrW-1:0] oaddr_ff;

   logic             we;
   logic [IdxW-1:0]  wa, ra;
   entry_type        wd, rd;
   logic [EntryW-1:0] rd_bits;

   dcc_ram #(.Width(EntryW), .Depth(RamD)) u_table (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_bits)
   );
   assign rd = entry_type'(rd_bits);

   logic out_free;
   logic emitting;
   assign out_free = !ov_ff || rsp.ready;
   assign emitting = (state_ff == ST_EMIT) || (state_ff == ST_REMIT);
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.packet_byte = ob_ff;
   assign rsp.end_of_packet = oeop_ff;
   assign rsp.priority_res = oprio_ff;
   assign rsp.repeat_count = orep_ff;
   assign rsp.target_address = oaddr_ff;
   assign rsp.last = olast_ff;

   // build speed packet bytes
   logic [7:0]       nb [4];
   logic [2:0]       nlen;
   logic [AddrW-1:0] n_addr;
   logic             n_lng, n_mode;
   logic [7:0]       n_step;
   always_comb begin
      nb[0] = '0; nb[1] = '0; nb[2] = '0; nb[3] = '0;
      nlen = 3'd0;
      if (n_lng || n_addr > AddrW'(limit_ff)) begin
         nb[0] = 8'hC0 | 8'(n_addr[13:8]);
         nb[1] = n_addr[7:0];
         nlen = 3'd2;
      end else begin
         nb[0] = n_addr[7:0];
         nlen = 3'd1;
      end
      if (n_mode) begin
         nb[nlen[1:0]] = code_28(n_step);
         nlen = nlen + 3'd1;
      end else begin
         nb[nlen[1:0]] = 8'h3F;
         nb[2'(nlen + 3'd1)] = n_step;
         nlen = nlen + 3'd2;
      end
   end

   logic new_lng;
   entry_type upd;
   assign new_lng = wlong_ff || addr_ff > AddrW'(limit_ff);

   always_comb begin
      n_addr = addr_ff; n_lng = 1'b0; n_step = 8'd1; n_mode = 1'b0;
      we = 1'b0; wa = idx_ff[IdxW-1:0]; wd = '0; ra = idx_ff[IdxW-1:0];
      upd = hit_e_ff;
      unique case (state_ff)
         ST_CLEAR: we = 1'b1;
         ST_DECIDE: begin
            unique case (kind_ff)
               KIND_FORGET: begin
                  n_lng = found_ff ? hit_e_ff.lng : addr_ff > AddrW'(limit_ff);
                  n_mode = found_ff ? hit_e_ff.mode : 1'b0;
               end
               KIND_ESTOP: begin
                  n_lng = found_ff ? hit_e_ff.lng : new_lng;
                  n_mode = found_ff ? hit_e_ff.mode : 1'b0;
               end
               default: begin
                  if (found_ff) upd.lng = new_lng;
                  else begin
                     upd.active = 1'b1; upd.addr = addr_ff; upd.lng = new_lng;
                     upd.step = 8'd0; upd.mode = newmode_ff;
                  end
                  if (kind_ff == KIND_THROTTLE) upd.step = step_ff;
                  n_lng = upd.lng; n_mode = upd.mode; n_step = upd.step;
               end
            endcase
         end
         ST_WRITE: begin
            we = 1'b1;
            wa = found_ff ? hit_ff : free_idx_ff;
            wd = hit_e_ff;
         end
         ST_RCHECK: begin
            n_addr = rd.addr; n_lng = rd.lng; n_step = rd.step; n_mode = rd.mode;
         end
         default: ;
      endcase
   end

   logic [PhW-1:0] phase_in;
   always_comb begin
      phase_in = phase_ff + PhW'(1);
      if (32'(phase_ff) + 1 >= REFRESH_PHASES) phase_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; idx_ff <= '0; limit_ff <= 8'd127;
         newmode_ff <= 1'b0; phase_ff <= '0; ov_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_SHORT_LIMIT) limit_ff <= csr_write_data;
            else newmode_ff <= csr_write_data[0];
         end
         if (ov_ff && rsp.ready && !emitting) ov_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               if (idx_ff == LastIdx) begin
                  state_ff <= ST_IDLE; idx_ff <= '0;
               end else idx_ff <= idx_ff + 1'b1;
            end
            ST_IDLE: if (req.valid) begin
               kind_ff <= req.kind; addr_ff <= req.loco_address;
               wlong_ff <= req.want_long;
               step_ff <= {req.forward_dir, req.speed_value};
               found_ff <= 1'b0; free_ff <= 1'b0; any_ff <= 1'b0; idx_ff <= '0;
               unique case (req.kind)
                  KIND_ENSURE, KIND_FORGET, KIND_THROTTLE, KIND_ESTOP:
                     state_ff <= ST_SREAD;
                  KIND_BCAST: begin
                     pb_ff[0] <= 8'h00; pb_ff[1] <= 8'h71; plen_ff <= 3'd2;
                     pos_ff <= '0; pprio_ff <= PRIO_EMERG; prep_ff <= 2'd3;
                     paddr_ff <= '0; more_ff <= 1'b0; state_ff <= ST_EMIT;
                  end
                  KIND_REFRESH: begin
                     phase_ff <= phase_in;
                     state_ff <= (phase_ff == '0) ? ST_SREAD : ST_IDLE;
                  end
                  default: ;
               endcase
            end
            ST_SREAD: state_ff <= ST_SCHECK;
            ST_SCHECK: begin
               if (rd.active && rd.addr == addr_ff && !found_ff) begin
                  found_ff <= 1'b1; hit_ff <= idx_ff[IdxW-1:0]; hit_e_ff <= rd;
               end
               if (!rd.active && !free_ff) begin
                  free_ff <= 1'b1; free_idx_ff <= idx_ff[IdxW-1:0];
               end
               if (rd.active) begin
                  any_ff <= 1'b1; lastact_ff <= idx_ff[IdxW-1:0];
               end
               if (idx_ff == LastIdx) begin
                  idx_ff <= '0;
                  if (kind_ff == KIND_REFRESH)
                     state_ff <= (any_ff || rd.active) ? ST_RREAD : ST_IDLE;
                  else state_ff <= ST_DECIDE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_SREAD;
               end
            end
            ST_DECIDE: begin
               pb_ff <= nb; plen_ff <= nlen; pos_ff <= '0; prep_ff <= 2'd0;
               paddr_ff <= addr_ff; more_ff <= 1'b0;
               unique case (kind_ff)
                  KIND_FORGET, KIND_ESTOP: begin
                     pprio_ff <= PRIO_EMERG;
                     hit_e_ff.active <= 1'b0;
                     state_ff <= (kind_ff == KIND_FORGET && found_ff) ? ST_WRITE
                                                                      : ST_EMIT;
                  end
                  default: begin
                     pprio_ff <= (step_ff < 8'd2) ? PRIO_EMERG : PRIO_HIGH;
                     hit_e_ff <= upd;
                     state_ff <= (found_ff || free_ff) ? ST_WRITE : ST_IDLE;
                  end
               endcase
            end
            ST_WRITE:
               state_ff <= (kind_ff == KIND_ENSURE) ? ST_IDLE : ST_EMIT;
            ST_EMIT, ST_REMIT: if (out_free) begin
               ov_ff <= 1'b1; ob_ff <= pb_ff[pos_ff[1:0]];
               oeop_ff <= (pos_ff + 3'd1 == plen_ff);
               olast_ff <= (pos_ff + 3'd1 == plen_ff) && !more_ff;
               oprio_ff <= pprio_ff; orep_ff <= prep_ff; oaddr_ff <= paddr_ff;
               pos_ff <= pos_ff + 3'd1;
               if (pos_ff + 3'd1 == plen_ff) begin
                  if (state_ff == ST_EMIT) state_ff <= ST_IDLE;
                  else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= (idx_ff == LastIdx || !more_ff) ? ST_IDLE
                                                                 : ST_RREAD;
                  end
               end
            end
            ST_RREAD: state_ff <= ST_RCHECK;
            ST_RCHECK: begin
               // emit if active, check for another active later entry
               if (rd.active) begin
                  pb_ff <= nb; plen_ff <= nlen; pos_ff <= '0;
                  pprio_ff <= PRIO_LOW; prep_ff <= 2'd0; paddr_ff <= rd.addr;
                  more_ff <= (idx_ff[IdxW-1:0] != lastact_ff);
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= (idx_ff == LastIdx) ? ST_IDLE : ST_RREAD;
               end
            end
            ST_DONE: state_ff <= ST_REMIT;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== hw/rtl/dcc_chk.sv =====
// port-level checker for the dcc packet generator, bound to the top level
// depends on dcc_pkg and the top level
`timescale 1ns / 1ps
module dcc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_last,
   input logic        rsp_end_of_packet,
   input logic [1:0]  rsp_priority_res,
   input logic [13:0] rsp_target_address
);
   import dcc_pkg::*;
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target_address))
      else $error("response changed under stall");
   a_last_eop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_end_of_packet)
      else $error("last without end of packet");
   a_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_priority_res != 2'd3)
      else $error("bad priority");
   a_no_accept_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");
endmodule

bind dcc_loco_table_speed_packet_gen_unit dcc_chk u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.last),
   .rsp_end_of_packet(rsp.end_of_packet), .rsp_priority_res(rsp.priority_res),
   .rsp_target_address(rsp.target_address)
);
